### rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Storage geometry.
    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;

    // Index, count and wrap-sum widths follow from the depth.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Fixed port field widths.
    localparam int CMD_W    = 3;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int ECOUNT_W = 5;
    localparam int STAT_W   = 2;

    // Command codes. Codes above the peek-right code are ignored.
    localparam logic [CMD_W-1:0] CMD_PUSH_R = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_L  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_R  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_L = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_R = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a command beat is taken this cycle
        logic load_out;  // capture the result into the output register
    } t_ctl_cmd;

endpackage

### rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences each command through accept and read-back, and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dq_pkg::t_ctl_cmd  o_cmd
);
    import dq_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   can_take;
    logic   accept;
    logic   out_taken;

    // A command is taken only when the output register will be free for it.
    assign out_taken = r_out_valid && !i_out_stall;
    assign can_take  = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall);
    assign accept    = i_in_valid && can_take;

    assign o_in_stall   = !can_take;
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept   = accept;
    assign o_cmd.load_out = (r_state == S_READ);

    // State and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (out_taken) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted command is always followed by its read-back cycle.
    a_accept_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted command not followed by read-back");

    // The output register must be empty when a result is loaded.
    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result loaded over a pending beat");

    // A new output beat appears only right after a read-back cycle.
    a_valid_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_READ))
        else $error("output valid rose without a read-back");

endmodule

### rtl/dq_dpath.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Head pointer, entry count, slot store and the output register.
// ----------------------------------------------------------------------------
module dq_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dq_pkg::t_ctl_cmd              i_cmd,
    input  logic [dq_pkg::CMD_W-1:0]      i_command,
    input  logic [dq_pkg::IN_W-1:0]       i_push_value,
    output logic [dq_pkg::OUT_W-1:0]      o_read_value,
    output logic                          o_now_empty,
    output logic [dq_pkg::ECOUNT_W-1:0]   o_entry_count,
    output logic [dq_pkg::STAT_W-1:0]     o_status
);
    import dq_pkg::*;

    logic [IDX_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      n_head;
    logic [CNT_W-1:0]      n_count;

    logic                  r_rd_use;
    logic [STAT_W-1:0]     r_status;
    logic                  n_rd_use;
    logic [STAT_W-1:0]     n_status;

    logic [OUT_W-1:0]      r_out_value;
    logic                  r_out_empty;
    logic [ECOUNT_W-1:0]   r_out_count;
    logic [STAT_W-1:0]     r_out_status;

    logic                  is_push;
    logic                  is_pop_l;
    logic                  is_pop_r;
    logic                  is_peek_l;
    logic                  is_left;
    logic                  is_read;
    logic                  full;
    logic                  empty;
    logic [SUM_W-1:0]      sum_tail;
    logic [SUM_W-1:0]      sum_last;
    logic [IDX_W-1:0]      tail_pos;
    logic [IDX_W-1:0]      last_pos;
    logic [IDX_W-1:0]      rd_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [WORD_WIDTH-1:0] ram_q;

    // Command decode.
    assign is_push   = (i_command == CMD_PUSH_R);
    assign is_pop_l  = (i_command == CMD_POP_L);
    assign is_pop_r  = (i_command == CMD_POP_R);
    assign is_peek_l = (i_command == CMD_PEEK_L);
    assign is_left   = is_pop_l || is_peek_l;
    assign is_read   = is_pop_l || is_pop_r || is_peek_l || (i_command == CMD_PEEK_R);

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Slot positions: the free slot past the right end and the rightmost entry.
    assign sum_tail = SUM_W'(r_head) + SUM_W'(r_count);
    assign sum_last = sum_tail - SUM_W'(1);
    assign tail_pos = (sum_tail >= SUM_W'(DEPTH)) ? IDX_W'(sum_tail - SUM_W'(DEPTH))
                                                  : IDX_W'(sum_tail);
    assign last_pos = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                  : IDX_W'(sum_last);
    assign rd_addr  = is_left ? r_head : last_pos;

    assign ram_we = i_cmd.accept && is_push && !full;
    assign ram_re = i_cmd.accept && is_read && !empty;

    // Next pointer, count and pending result fields.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rd_use = 1'b0;
        n_status = ST_OK;
        if (is_push) begin
            if (full) begin
                n_status = ST_OVER;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (is_read) begin
            if (empty) begin
                n_status = ST_UNDER;
            end else begin
                n_rd_use = 1'b1;
                if (is_pop_l) begin
                    n_head  = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
                    n_count = r_count - CNT_W'(1);
                end else if (is_pop_r) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    // Pointer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Pending result fields, held until the read data returns.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_use <= n_rd_use;
            r_status <= n_status;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value  <= r_rd_use ? OUT_W'(ram_q) : '0;
            r_out_empty  <= (r_count == '0);
            r_out_count  <= ECOUNT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    // Slot store.
    dq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail_pos),
        .i_wdata (WORD_WIDTH'(i_push_value)),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign o_read_value  = r_out_value;
    assign o_now_empty   = r_out_empty;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds capacity");

    // The head does not move unless a command is accepted.
    a_head_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.accept |=> $stable(r_head))
        else $error("head moved without a command");

endmodule

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque in a circular buffer: push right, pop or peek at either end,
// one result beat per command.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    i_command, i_push_value
//  out      output     o_out_valid / i_out_stall  o_read_value, o_now_empty,
//                                                 o_entry_count, o_status
//
//  Each command first updates the head and count and addresses the slot
//  store, then loads the registered store read into the output
//  register.
//  Reset clears the head, the count and the output valid flag; the slot
//  store contents are unknown until written.
//  A result beat waits in the output register while o_out_valid is stalled;
//  the next command is taken once that beat leaves or in the cycle it leaves.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dq_pkg::CMD_W-1:0]      i_command,
    input  logic [dq_pkg::IN_W-1:0]       i_push_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dq_pkg::OUT_W-1:0]      o_read_value,
    output logic                          o_now_empty,
    output logic [dq_pkg::ECOUNT_W-1:0]   o_entry_count,
    output logic [dq_pkg::STAT_W-1:0]     o_status
);
    import dq_pkg::*;

    t_ctl_cmd ctl_cmd;

    // Sequencing.
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (ctl_cmd)
    );

    // Storage and result datapath.
    dq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctl_cmd),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .o_read_value  (o_read_value),
        .o_now_empty   (o_now_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

endmodule

### test/dq_checker.sv
// ----------------------------------------------------------------------------
// Deque result checker
// Watches the command and result channels of the double-ended queue, keeps
// its own copy of the queue contents, head and count, and compares every
// result beat field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module dq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [dq_pkg::CMD_W-1:0]      i_command,
    input  logic [dq_pkg::IN_W-1:0]       i_push_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [dq_pkg::OUT_W-1:0]      i_read_value,
    input  logic                          i_now_empty,
    input  logic [dq_pkg::ECOUNT_W-1:0]   i_entry_count,
    input  logic [dq_pkg::STAT_W-1:0]     i_status,
    output int                            o_fail_count,
    output int                            o_pending
);
    import dq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OUT_W-1:0]    read_value;
        logic                now_empty;
        logic [ECOUNT_W-1:0] entry_count;
        logic [STAT_W-1:0]   status;
    } t_deque_result;

    // Shadow copy of the queue.
    logic [WORD_WIDTH-1:0] shadow_slots [DEPTH];
    int unsigned           shadow_head;
    int unsigned           shadow_count;

    t_deque_result queued_results[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    // Apply one command to the shadow queue and return the result it owes.
    function automatic t_deque_result apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [IN_W-1:0]  word);
        t_deque_result    res;
        logic [IDX_W-1:0] pos;
        res = '0;
        res.status = ST_OK;
        if (cmd == CMD_PUSH_R) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_OVER;
            end else begin
                pos = IDX_W'((shadow_head + shadow_count) % DEPTH);
                shadow_slots[pos] = WORD_WIDTH'(word);
                shadow_count++;
            end
        end else if (cmd >= CMD_POP_L && cmd <= CMD_PEEK_R) begin
            if (shadow_count == 0) begin
                res.status = ST_UNDER;
            end else begin
                if (cmd == CMD_POP_L || cmd == CMD_PEEK_L) begin
                    pos = IDX_W'(shadow_head);
                end else begin
                    pos = IDX_W'((shadow_head + shadow_count - 1) % DEPTH);
                end
                res.read_value = OUT_W'(shadow_slots[pos]);
                if (cmd == CMD_POP_L) begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end else if (cmd == CMD_POP_R) begin
                    shadow_count--;
                end
            end
        end
        res.now_empty   = (shadow_count == 0);
        res.entry_count = ECOUNT_W'(shadow_count);
        return res;
    endfunction

    // Predict on every command beat, compare on every result beat.
    always @(posedge i_clk) begin
        t_deque_result seen;
        t_deque_result want;
        if (!i_rst_n) begin
            shadow_head  = 0;
            shadow_count = 0;
            queued_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                queued_results.insert(queued_results.size(),
                                      apply_command(i_command, i_push_value));
            end
            if (i_out_valid && !i_out_stall) begin
                seen.read_value  = i_read_value;
                seen.now_empty   = i_now_empty;
                seen.entry_count = i_entry_count;
                seen.status      = i_status;
                if (queued_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display({"deque: unexpected result beat ",
                                  "read=%h empty=%0d count=%0d status=%0d"},
                                 seen.read_value, seen.now_empty, seen.entry_count,
                                 seen.status);
                    end
                end else begin
                    want = queued_results.pop_front();
                    if (seen.read_value !== want.read_value ||
                        seen.now_empty !== want.now_empty ||
                        seen.entry_count !== want.entry_count ||
                        seen.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display({"deque: mismatch expected ",
                                      "read=%h empty=%0d count=%0d status=%0d"},
                                     want.read_value, want.now_empty,
                                     want.entry_count, want.status);
                            $display({"deque:          actual   ",
                                      "read=%h empty=%0d count=%0d status=%0d"},
                                     seen.read_value, seen.now_empty,
                                     seen.entry_count, seen.status);
                        end
                    end
                end
            end
        end
        o_pending <= queued_results.size();
    end

endmodule

### test/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives directed and random command beats into the deque with random gaps on
// both channels, including a long result hold-off and a full drain mid-run.
// A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 100;
    localparam int PAUSE_AT     = 800;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 8;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_PEEK_R + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_command;
    logic [IN_W-1:0]       i_push_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [OUT_W-1:0]      o_read_value;
    logic                  o_now_empty;
    logic [ECOUNT_W-1:0]   o_entry_count;
    logic [STAT_W-1:0]     o_status;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int cycle_count = 0;
    bit held_once;
    bit quiet;

    double_ended_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_now_empty   (o_now_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    dq_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_read_value  (o_read_value),
        .i_now_empty   (o_now_empty),
        .i_entry_count (o_entry_count),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Data words with the all-zero and all-one patterns mixed in.
    function automatic logic [IN_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Command mix leaning toward pushes by push_pct, with a few ignored codes.
    function automatic logic [CMD_W-1:0] pick_command(input int push_pct);
        if ($urandom_range(0, 99) < 3) begin
            return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        if ($urandom_range(0, 99) < push_pct) return CMD_PUSH_R;
        case ($urandom_range(0, 3))
            0:       return CMD_POP_L;
            1:       return CMD_POP_R;
            2:       return CMD_PEEK_L;
            default: return CMD_PEEK_R;
        endcase
    endfunction

    // Offer one command beat and wait until it is taken.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IN_W-1:0] word);
        int gap;
        gap = quiet ? 0 : idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= word;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Result side: random stalls, quiet stretches and one long hold-off.
    initial begin
        int run;
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held_once && items_sent >= HOLD_AT) begin
                held_once = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
            run = idle_cycles();
            if (run > 0) begin
                i_out_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // Command side and verdict.
    initial begin
        int  random_sent;
        int  seg_left;
        int  push_pct;
        bit  paused_once;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_command    <= CMD_PUSH_R;
        i_push_value <= '0;
        random_sent  = 0;
        paused_once  = 1'b0;
        quiet        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every read command on an empty queue underflows.
        issue(CMD_POP_L, '1);
        issue(CMD_POP_R, '1);
        issue(CMD_PEEK_L, '0);
        issue(CMD_PEEK_R, '0);
        // Extreme words, reads at both ends, pops down to empty and past it.
        issue(CMD_PUSH_R, '1);
        issue(CMD_PEEK_L, '0);
        issue(CMD_PEEK_R, '0);
        issue(CMD_PUSH_R, '0);
        issue(CMD_PEEK_R, '1);
        issue(CMD_POP_R, '0);
        issue(CMD_POP_L, '0);
        issue(CMD_POP_L, '0);
        // Ignored command codes leave the queue alone.
        issue(CMD_SPARE_FIRST, '1);
        issue(CMD_SPARE_FIRST + 3'd1, 32'h5A5A_5A5A);
        issue(CMD_SPARE_LAST, 32'hA5A5_A5A5);
        // A left pop that empties the queue still advances the head.
        issue(CMD_PUSH_R, 32'hA5A5_A5A5);
        issue(CMD_POP_L, '0);
        issue(CMD_PUSH_R, 32'h5A5A_5A5A);
        issue(CMD_PUSH_R, 32'h0000_0001);
        issue(CMD_PEEK_L, '0);
        issue(CMD_POP_R, '0);
        issue(CMD_POP_L, '0);

        // Random segments that drift the queue toward full, toward empty,
        // or hover around the middle.
        while (random_sent < RANDOM_ITEMS) begin
            seg_left = $urandom_range(8, 48);
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 20;
                default: push_pct = 45;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            while (seg_left > 0 && random_sent < RANDOM_ITEMS) begin
                if (!paused_once && items_sent >= PAUSE_AT) begin
                    paused_once = 1'b1;
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
                issue(pick_command(push_pct), pick_word());
                seg_left--;
                random_sent++;
            end
        end

        // Drain and settle.
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/dq_dpath.sv
rtl/double_ended_queue.sv
test/dq_checker.sv
test/double_ended_queue_tb.sv
